// ===== rtl/xts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML token splitter package
// Buffer sizing, delimiter characters and token kind codes.
// ----------------------------------------------------------------------------
package xts_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [1:0] KIND_TAG     = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_KEY     = 2'd2;
  localparam logic [1:0] KIND_VALUE   = 2'd3;

  localparam logic [3:0] MASK_RESET = 4'hF;

endpackage

// ===== rtl/xml_token_splitter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML token splitter core
// Splits an XML byte stream into tag, content, key and value tokens.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall / input_byte, one character per word.
// Output channel: out_valid / out_stall with token_kind, token_byte,
// token_end and token_truncated, one token character per word.
// Config: cfg_write / cfg_data write kind_enable_mask (tag, content, key,
// value enable bits); write only while the block is idle.
// An ordinary character is written to the token memory while it has room;
// past that it is dropped and the token marked truncated. A delimiter that
// closes an enabled, non-empty token starts a flush: the token is read back
// from the single-port memory, one word per cycle while the output is not
// stalled, each word registered into the output; input is held meanwhile.
// A delimiter that emits nothing does not stall the input.
// The receiver may stall at any time: the output word holds and the memory
// read pauses; input is taken again once the last read has been issued,
// even while that last word waits on the output.
// Reset (synchronous, active high) sets the before-header mode, empties the
// buffer, enables all kinds and drops any pending output.
// ----------------------------------------------------------------------------
module xml_token_splitter_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] input_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_kind,
  output logic [7:0] token_byte,
  output logic       token_end,
  output logic       token_truncated
);

  typedef enum logic [2:0] {
    MODE_BEFORE  = 3'd0,
    MODE_HEADER  = 3'd1,
    MODE_TAG     = 3'd2,
    MODE_KEY     = 3'd3,
    MODE_VALUE   = 3'd4,
    MODE_CONTENT = 3'd5
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_t;

  state_t state;
  mode_t  mode;
  mode_t  mode_next;

  logic [3:0]                    kind_enable_mask;
  logic [xts_pkg::CNT_W-1:0]     fill_count;
  logic                          overflow_flag;
  logic [xts_pkg::ADDR_W-1:0]    rd_idx;
  logic [xts_pkg::ADDR_W-1:0]    run_last;
  logic [1:0]                    run_kind;
  logic                          run_trunc;

  logic [7:0] token_mem [xts_pkg::BUFFER_DEPTH];

  logic                       in_take;
  logic                       is_delim;
  logic                       emit_req;
  logic [1:0]                 emit_kind;
  logic [xts_pkg::CNT_W-1:0]  emit_len;
  logic                       emit_go;
  logic                       buf_full;
  logic                       wr_en;
  logic                       rd_en;
  logic                       rd_last;

  assign in_stall = (state == ST_FLUSH);
  assign in_take  = in_valid && !in_stall;
  assign buf_full = (fill_count == xts_pkg::CNT_W'(xts_pkg::BUFFER_DEPTH));
  assign rd_en    = (state == ST_FLUSH) && (!out_valid || !out_stall);
  assign rd_last  = (rd_idx == run_last);

  always_comb begin
    is_delim  = 1'b0;
    emit_req  = 1'b0;
    emit_kind = xts_pkg::KIND_TAG;
    emit_len  = fill_count;
    mode_next = mode;
    case (mode)
      MODE_BEFORE: begin
        if (input_byte == xts_pkg::CH_LT) begin
          is_delim  = 1'b1;
          mode_next = MODE_BEFORE;
        end else if (input_byte == xts_pkg::CH_QMARK) begin
          is_delim  = 1'b1;
          mode_next = MODE_HEADER;
        end
      end
      MODE_HEADER: begin
        if (input_byte == xts_pkg::CH_GT) begin
          is_delim  = 1'b1;
          mode_next = MODE_CONTENT;
        end
      end
      MODE_TAG: begin
        if (input_byte == xts_pkg::CH_GT || input_byte == xts_pkg::CH_SPACE) begin
          is_delim  = 1'b1;
          emit_req  = 1'b1;
          emit_kind = xts_pkg::KIND_TAG;
          mode_next = (input_byte == xts_pkg::CH_GT) ? MODE_CONTENT : MODE_KEY;
        end
      end
      MODE_KEY: begin
        if (input_byte == xts_pkg::CH_GT) begin
          is_delim  = 1'b1;
          mode_next = MODE_CONTENT;
        end else if (input_byte == xts_pkg::CH_QUOTE) begin
          is_delim  = 1'b1;
          emit_req  = 1'b1;
          emit_kind = xts_pkg::KIND_KEY;
          emit_len  = (fill_count != '0) ? fill_count - 1'b1 : fill_count;
          mode_next = MODE_VALUE;
        end
      end
      MODE_VALUE: begin
        if (input_byte == xts_pkg::CH_QUOTE) begin
          is_delim  = 1'b1;
          emit_req  = 1'b1;
          emit_kind = xts_pkg::KIND_VALUE;
          mode_next = MODE_TAG;
        end
      end
      MODE_CONTENT: begin
        if (input_byte == xts_pkg::CH_LT) begin
          is_delim  = 1'b1;
          emit_req  = 1'b1;
          emit_kind = xts_pkg::KIND_CONTENT;
          mode_next = MODE_TAG;
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  assign emit_go = emit_req && (emit_len != '0) && kind_enable_mask[emit_kind];
  assign wr_en   = in_take && !is_delim && !buf_full;

  // token memory: one write port, registered read feeds the output word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      token_mem[fill_count[xts_pkg::ADDR_W-1:0]] <= input_byte;
    end
    if (rd_en) begin
      token_byte <= token_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      mode             <= MODE_BEFORE;
      kind_enable_mask <= xts_pkg::MASK_RESET;
      fill_count       <= '0;
      overflow_flag    <= 1'b0;
      out_valid        <= 1'b0;
      rd_idx           <= '0;
    end else begin
      if (cfg_write) begin
        kind_enable_mask <= cfg_data;
      end
      if (in_take) begin
        if (is_delim) begin
          mode          <= mode_next;
          fill_count    <= '0;
          overflow_flag <= 1'b0;
          if (emit_go) begin
            state     <= ST_FLUSH;
            rd_idx    <= '0;
            run_last  <= xts_pkg::ADDR_W'(emit_len - 1'b1);
            run_kind  <= emit_kind;
            run_trunc <= overflow_flag;
          end
        end else if (buf_full) begin
          overflow_flag <= 1'b1;
        end else begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (rd_en) begin
        out_valid       <= 1'b1;
        token_kind      <= run_kind;
        token_end       <= rd_last;
        token_truncated <= run_trunc;
        if (rd_last) begin
          state <= ST_IDLE;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_flush_empty_buf: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (fill_count == '0))
    else $error("buffer not empty during flush");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= xts_pkg::CNT_W'(xts_pkg::BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> buf_full)
    else $error("overflow set with room left");

  a_last_read_idle: assert property (@(posedge clk) disable iff (rst)
    (rd_en && rd_last) |=> (state == ST_IDLE && out_valid && token_end))
    else $error("last read did not end flush");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_valid && out_stall) |=> $stable(rd_idx))
    else $error("read advanced under output stall");
`endif

endmodule
